/* src/two_axis_stepper_raster_positioner_assert.svh */
// Assertion macros for the two-axis stepper raster positioner.
// Used by the top level only; the macros expect clk and rst_n in scope.
`ifndef TWO_AXIS_STEPPER_RASTER_POSITIONER_ASSERT_SVH
`define TWO_AXIS_STEPPER_RASTER_POSITIONER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TASRP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("two-axis positioner check failed");

// Next-cycle implication, checked outside reset.
`define TASRP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("two-axis positioner check failed");

`endif

/* src/tasrp_pkg.sv */
// Shared types and constants for the two-axis stepper raster positioner.
// No dependencies; every module of the block imports this package.
package tasrp_pkg;

    localparam int POS_W      = 32;
    localparam int REM_W      = 33;
    localparam int CELL_W     = 7;
    localparam int SCALE_W    = 16;
    localparam int PROD_W     = SCALE_W + CELL_W;
    localparam int DIFF_W     = POS_W + 2;
    localparam int CMD_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Request command codes.
    localparam logic [CMD_W-1:0] CMD_TICK      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET_ZERO  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_GOTO_CELL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_GOTO_NEXT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ENABLE    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DISABLE   = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_X_NUM   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_DEN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_NUM   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_DEN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMIT,
        ST_MUL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_PLAN
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic mul_load;
        logic div_start;
        logic plan;
        logic axis_y;
        logic out_load;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_busy;
        logic arrived;
        logic rem_zero;
        logic all_done;
    } dp_stat_t;

endpackage

/* src/two_axis_stepper_raster_positioner.sv */
// Two-axis step/direction generator with serpentine grid scan, top level.
// Depends on tasrp_pkg, tasrp_ctrl, tasrp_dp and the assertion macro header.
//
// Usage: each request on the input channel (in_valid/in_stall) carries a command
// and its operands and yields exactly one result on the output channel
// (out_valid/out_stall): step levels, directions, positions, the current cell,
// the arrived flag and the sticky scan_done flag, all as they stand after the
// command. Configuration registers are written through cfg_write, cfg_index and
// cfg_data, and must only be written while no request is in flight.
// For tick, set_zero, enable, disable and unknown codes the request is taken
// in idle and the result register is loaded from the emit state once the
// output register is free. Goto_cell and goto_next pass through the shared
// restoring divider, which forms floor(num*cell/den) for each axis; the X
// and Y plans run one after the other through it.
// The block takes one request at a time; in_stall is high from the cycle after
// a request is taken until its result has been loaded into the output register.
// The output register frees the input side: a stalled result stays on the
// output ports while the next request is taken and worked on; its own result
// then waits in the controller until the register is free.
// Reset clears all axis state, disables stepping and sets every scale and grid
// register to one; no result is pending after reset.
`include "two_axis_stepper_raster_positioner_assert.svh"

module two_axis_stepper_raster_positioner
    import tasrp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // Configuration write port.
    input  logic                    cfg_write,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    // Request channel.
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [CMD_W-1:0]        command,
    input  logic signed [POS_W-1:0] zero_x,
    input  logic signed [POS_W-1:0] zero_y,
    input  logic [CELL_W-1:0]       cell_x,
    input  logic [CELL_W-1:0]       cell_y,
    // Result channel.
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    step_x,
    output logic                    step_y,
    output logic                    dir_x,
    output logic                    dir_y,
    output logic signed [POS_W-1:0] pos_x,
    output logic signed [POS_W-1:0] pos_y,
    output logic [CELL_W-1:0]       at_cell_x,
    output logic [CELL_W-1:0]       at_cell_y,
    output logic                    arrived,
    output logic                    scan_done
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // The controller decides when a request is taken, when each axis is
    // planned and when the result register may be loaded.
    tasrp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .command   (command),
        .out_stall (out_stall),
        .stat      (stat),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    // The datapath holds the configuration, the axis state, the divider and
    // the result register.
    tasrp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .command   (command),
        .zero_x    (zero_x),
        .zero_y    (zero_y),
        .cell_x    (cell_x),
        .cell_y    (cell_y),
        .stat      (stat),
        .step_x    (step_x),
        .step_y    (step_y),
        .dir_x     (dir_x),
        .dir_y     (dir_y),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .at_cell_x (at_cell_x),
        .at_cell_y (at_cell_y),
        .arrived   (arrived),
        .scan_done (scan_done)
    );

    // A running division must hold off new requests.
    `TASRP_ASSERT_IMP(a_div_busy_stalls, stat.div_busy, in_stall)
    // Arrived is only ever set with both step counts exhausted.
    `TASRP_ASSERT_IMP(a_arrived_at_rest, stat.arrived, stat.rem_zero)
    // The end-of-scan flag is cleared by reset alone.
    `TASRP_ASSERT_NXT(a_scan_done_sticky, stat.all_done, stat.all_done)

endmodule

/* src/tasrp_div.sv */
// Restoring divider, one quotient bit per cycle, for the step target.
// Depends on tasrp_pkg for the operand widths.
module tasrp_div
    import tasrp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [PROD_W-1:0]  dividend,
    input  logic [SCALE_W-1:0] divisor,
    output logic               busy,
    output logic [PROD_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(PROD_W + 1);

    logic [PROD_W-1:0]  q_reg, q_next;
    logic [SCALE_W-1:0] r_reg, r_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic [SCALE_W:0]   shifted;
    logic [SCALE_W:0]   trial;

    assign shifted = {r_reg, q_reg[PROD_W-1]};
    assign trial   = shifted - {1'b0, divisor};

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            cnt_next  = CNT_W'(PROD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, divisor})
            begin
                r_next = trial[SCALE_W-1:0];
                q_next = {q_reg[PROD_W-2:0], 1'b1};
            end
            else
            begin
                r_next = shifted[SCALE_W-1:0];
                q_next = {q_reg[PROD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule

/* src/tasrp_dp.sv */
// Datapath: configuration, axis state, serpentine walk, target planning
// and the output register. Depends on tasrp_pkg and tasrp_div.
module tasrp_dp
    import tasrp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  ctrl_cmd_t              cmd,
    input  logic [CMD_W-1:0]       command,
    input  logic signed [POS_W-1:0] zero_x,
    input  logic signed [POS_W-1:0] zero_y,
    input  logic [CELL_W-1:0]      cell_x,
    input  logic [CELL_W-1:0]      cell_y,
    output dp_stat_t               stat,
    output logic                   step_x,
    output logic                   step_y,
    output logic                   dir_x,
    output logic                   dir_y,
    output logic signed [POS_W-1:0] pos_x,
    output logic signed [POS_W-1:0] pos_y,
    output logic [CELL_W-1:0]      at_cell_x,
    output logic [CELL_W-1:0]      at_cell_y,
    output logic                   arrived,
    output logic                   scan_done
);

    // Configuration.
    logic [SCALE_W-1:0] x_num_reg, x_num_next, x_den_reg, x_den_next;
    logic [SCALE_W-1:0] y_num_reg, y_num_next, y_den_reg, y_den_next;
    logic [CELL_W-1:0]  cols_reg, cols_next, rows_reg, rows_next;

    // Axis and scan state.
    logic [POS_W-1:0]  posx_reg, posx_next, posy_reg, posy_next;
    logic [REM_W-1:0]  remx_reg, remx_next, remy_reg, remy_next;
    logic              dirx_reg, dirx_next, diry_reg, diry_next;
    logic              phase_reg, phase_next;
    logic              lvlx_reg, lvlx_next, lvly_reg, lvly_next;
    logic [CELL_W-1:0] cellx_reg, cellx_next, celly_reg, celly_next;
    logic              arrived_reg, arrived_next;
    logic              done_reg, done_next;
    logic              running_reg, running_next;

    // Working registers of a move.
    logic [CELL_W-1:0] tgtx_reg, tgtx_next, tgty_reg, tgty_next;
    logic [PROD_W-1:0] prod_reg;

    // Output register.
    logic              o_stepx_reg, o_stepy_reg, o_dirx_reg, o_diry_reg;
    logic [POS_W-1:0]  o_posx_reg, o_posy_reg;
    logic [CELL_W-1:0] o_cellx_reg, o_celly_reg;
    logic              o_arr_reg, o_done_reg;

    // Serpentine walk.
    logic [CELL_W-1:0] cols_eff, rows_eff;
    logic [CELL_W:0]   walk_x, walk_y;
    logic              walk_end;

    // Planning.
    logic [SCALE_W-1:0] den_sel, num_sel;
    logic [CELL_W-1:0]  cell_sel;
    logic [POS_W-1:0]   pos_sel;
    logic               div_busy;
    logic [PROD_W-1:0]  target;
    logic [DIFF_W-1:0]  diff_up, diff_dn;
    logic               go_up;
    logic [REM_W-1:0]   plan_rem;

    assign cols_eff = (cols_reg == '0) ? CELL_W'(1) : cols_reg;
    assign rows_eff = (rows_reg == '0) ? CELL_W'(1) : rows_reg;

    // Next cell of the scan: even rows run forward, odd rows run back.
    always_comb
    begin
        walk_x   = {1'b0, cellx_reg};
        walk_y   = {1'b0, celly_reg};
        walk_end = 1'b0;
        if (!celly_reg[0])
        begin
            walk_x = {1'b0, cellx_reg} + 1'b1;
            if (walk_x >= {1'b0, cols_eff})
            begin
                walk_y = {1'b0, celly_reg} + 1'b1;
                walk_x = {1'b0, cols_eff} - 1'b1;
            end
        end
        else if (cellx_reg == '0)
        begin
            walk_y = {1'b0, celly_reg} + 1'b1;
            walk_x = '0;
        end
        else
        begin
            walk_x = {1'b0, cellx_reg} - 1'b1;
        end
        if (walk_y >= {1'b0, rows_eff})
        begin
            walk_y   = {1'b0, rows_eff} - 1'b1;
            walk_end = 1'b1;
        end
    end

    assign num_sel  = cmd.axis_y ? y_num_reg : x_num_reg;
    assign den_sel  = cmd.axis_y ? ((y_den_reg == '0) ? SCALE_W'(1) : y_den_reg)
                                 : ((x_den_reg == '0) ? SCALE_W'(1) : x_den_reg);
    assign cell_sel = cmd.axis_y ? tgty_reg : tgtx_reg;
    assign pos_sel  = cmd.axis_y ? posy_reg : posx_reg;

    tasrp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (den_sel),
        .busy     (div_busy),
        .quotient (target)
    );

    // Target minus position and its negation, both at full width.
    assign diff_up  = {{(DIFF_W-PROD_W){1'b0}}, target} - {{2{pos_sel[POS_W-1]}}, pos_sel};
    assign diff_dn  = {{2{pos_sel[POS_W-1]}}, pos_sel} - {{(DIFF_W-PROD_W){1'b0}}, target};
    assign go_up    = !diff_up[DIFF_W-1] && (diff_up != '0);
    assign plan_rem = go_up ? diff_up[REM_W-1:0] : diff_dn[REM_W-1:0];

    always_comb
    begin
        x_num_next   = x_num_reg;
        x_den_next   = x_den_reg;
        y_num_next   = y_num_reg;
        y_den_next   = y_den_reg;
        cols_next    = cols_reg;
        rows_next    = rows_reg;
        posx_next    = posx_reg;
        posy_next    = posy_reg;
        remx_next    = remx_reg;
        remy_next    = remy_reg;
        dirx_next    = dirx_reg;
        diry_next    = diry_reg;
        phase_next   = phase_reg;
        lvlx_next    = lvlx_reg;
        lvly_next    = lvly_reg;
        cellx_next   = cellx_reg;
        celly_next   = celly_reg;
        arrived_next = arrived_reg;
        done_next    = done_reg;
        running_next = running_reg;
        tgtx_next    = tgtx_reg;
        tgty_next    = tgty_reg;

        if (cfg_write)
        begin
            case (cfg_index)
                CFG_X_NUM:   x_num_next = cfg_data;
                CFG_X_DEN:   x_den_next = cfg_data;
                CFG_Y_NUM:   y_num_next = cfg_data;
                CFG_Y_DEN:   y_den_next = cfg_data;
                CFG_COLUMNS: cols_next  = cfg_data[CELL_W-1:0];
                CFG_ROWS:    rows_next  = cfg_data[CELL_W-1:0];
                default:     ;
            endcase
        end

        if (cmd.accept)
        begin
            case (command)
                CMD_TICK:
                begin
                    if (running_reg)
                    begin
                        if (phase_reg)
                        begin
                            lvlx_next = 1'b0;
                            lvly_next = 1'b0;
                            if (remx_reg != '0)
                            begin
                                arrived_next = 1'b0;
                                posx_next    = dirx_reg ? posx_reg + 1'b1 : posx_reg - 1'b1;
                                lvlx_next    = 1'b1;
                                remx_next    = remx_reg - 1'b1;
                            end
                            if (remy_reg != '0)
                            begin
                                arrived_next = 1'b0;
                                posy_next    = diry_reg ? posy_reg + 1'b1 : posy_reg - 1'b1;
                                lvly_next    = 1'b1;
                                remy_next    = remy_reg - 1'b1;
                            end
                            phase_next = 1'b0;
                        end
                        else
                        begin
                            lvlx_next  = 1'b0;
                            lvly_next  = 1'b0;
                            phase_next = 1'b1;
                        end
                        if (remx_next == '0 && remy_next == '0)
                        begin
                            arrived_next = 1'b1;
                        end
                    end
                end
                CMD_SET_ZERO:
                begin
                    posx_next  = zero_x;
                    posy_next  = zero_y;
                    cellx_next = '0;
                    celly_next = '0;
                end
                CMD_GOTO_CELL:
                begin
                    tgtx_next = cell_x;
                    tgty_next = cell_y;
                end
                CMD_GOTO_NEXT:
                begin
                    tgtx_next = walk_x[CELL_W-1:0];
                    tgty_next = walk_y[CELL_W-1:0];
                    if (walk_end)
                    begin
                        done_next = 1'b1;
                    end
                end
                CMD_ENABLE:
                begin
                    running_next = 1'b1;
                    phase_next   = 1'b0;
                    dirx_next    = 1'b0;
                    diry_next    = 1'b0;
                    remx_next    = '0;
                    remy_next    = '0;
                    arrived_next = 1'b0;
                end
                CMD_DISABLE:
                begin
                    running_next = 1'b0;
                    lvlx_next    = 1'b0;
                    lvly_next    = 1'b0;
                end
                default: ;
            endcase
        end

        // The Y plan closes the move, so the cell is committed there. Arrived
        // drops already with the X plan, as the X count may now be nonzero.
        if (cmd.plan)
        begin
            if (cmd.axis_y)
            begin
                remy_next    = plan_rem;
                diry_next    = go_up;
                cellx_next   = tgtx_reg;
                celly_next   = tgty_reg;
                arrived_next = 1'b0;
            end
            else
            begin
                remx_next    = plan_rem;
                dirx_next    = go_up;
                arrived_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_num_reg   <= SCALE_W'(1);
            x_den_reg   <= SCALE_W'(1);
            y_num_reg   <= SCALE_W'(1);
            y_den_reg   <= SCALE_W'(1);
            cols_reg    <= CELL_W'(1);
            rows_reg    <= CELL_W'(1);
            posx_reg    <= '0;
            posy_reg    <= '0;
            remx_reg    <= '0;
            remy_reg    <= '0;
            dirx_reg    <= 1'b0;
            diry_reg    <= 1'b0;
            phase_reg   <= 1'b0;
            lvlx_reg    <= 1'b0;
            lvly_reg    <= 1'b0;
            cellx_reg   <= '0;
            celly_reg   <= '0;
            arrived_reg <= 1'b0;
            done_reg    <= 1'b0;
            running_reg <= 1'b0;
        end
        else
        begin
            x_num_reg   <= x_num_next;
            x_den_reg   <= x_den_next;
            y_num_reg   <= y_num_next;
            y_den_reg   <= y_den_next;
            cols_reg    <= cols_next;
            rows_reg    <= rows_next;
            posx_reg    <= posx_next;
            posy_reg    <= posy_next;
            remx_reg    <= remx_next;
            remy_reg    <= remy_next;
            dirx_reg    <= dirx_next;
            diry_reg    <= diry_next;
            phase_reg   <= phase_next;
            lvlx_reg    <= lvlx_next;
            lvly_reg    <= lvly_next;
            cellx_reg   <= cellx_next;
            celly_reg   <= celly_next;
            arrived_reg <= arrived_next;
            done_reg    <= done_next;
            running_reg <= running_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tgtx_reg <= tgtx_next;
        tgty_reg <= tgty_next;
        if (cmd.mul_load)
        begin
            prod_reg <= PROD_W'(num_sel) * PROD_W'(cell_sel);
        end
        if (cmd.out_load)
        begin
            o_stepx_reg <= lvlx_reg;
            o_stepy_reg <= lvly_reg;
            o_dirx_reg  <= dirx_reg;
            o_diry_reg  <= diry_reg;
            o_posx_reg  <= posx_reg;
            o_posy_reg  <= posy_reg;
            o_cellx_reg <= cellx_reg;
            o_celly_reg <= celly_reg;
            o_arr_reg   <= arrived_reg;
            o_done_reg  <= done_reg;
        end
    end

    assign stat.div_busy = div_busy;
    assign stat.arrived  = arrived_reg;
    assign stat.rem_zero = (remx_reg == '0) && (remy_reg == '0);
    assign stat.all_done = done_reg;

    assign step_x    = o_stepx_reg;
    assign step_y    = o_stepy_reg;
    assign dir_x     = o_dirx_reg;
    assign dir_y     = o_diry_reg;
    assign pos_x     = o_posx_reg;
    assign pos_y     = o_posy_reg;
    assign at_cell_x = o_cellx_reg;
    assign at_cell_y = o_celly_reg;
    assign arrived   = o_arr_reg;
    assign scan_done = o_done_reg;

endmodule

/* src/tasrp_ctrl.sv */
// Controller: sequences request intake, the two axis plans and result delivery.
// Depends on tasrp_pkg for the state, command and status types.
module tasrp_ctrl
    import tasrp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [CMD_W-1:0] command,
    input  logic             out_stall,
    input  dp_stat_t         stat,
    output logic             in_stall,
    output logic             out_valid,
    output ctrl_cmd_t        cmd
);

    ctrl_state_t state_reg, state_next;
    logic        axis_reg, axis_next;
    logic        out_valid_reg, out_valid_next;
    logic        accept;
    logic        is_move;
    logic        out_free;

    assign accept   = (state_reg == ST_IDLE) && in_valid;
    assign is_move  = (command == CMD_GOTO_CELL) || (command == CMD_GOTO_NEXT);
    assign out_free = !out_valid_reg || !out_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    axis_next  = 1'b0;
                    state_next = is_move ? ST_MUL : ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MUL:       state_next = ST_DIV_START;
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    state_next = ST_PLAN;
                end
            end
            ST_PLAN:
            begin
                if (axis_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    axis_next  = 1'b1;
                    state_next = ST_MUL;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd           = '0;
        cmd.axis_y    = axis_reg;
        cmd.accept    = accept;
        cmd.mul_load  = (state_reg == ST_MUL);
        cmd.div_start = (state_reg == ST_DIV_START);
        cmd.plan      = (state_reg == ST_PLAN);
        cmd.out_load  = (state_reg == ST_EMIT) && out_free;
        in_stall      = (state_reg != ST_IDLE);
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
